>>> rtl/jewd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jewd_pkg;

    // Block sizing
    localparam int NUM_JOINTS    = 6;
    localparam int MAP_SLOTS     = 12;
    localparam int MAP_W         = 2 * MAP_SLOTS;
    localparam int ERR_KINDS     = 3;
    localparam int NUM_CNT       = NUM_JOINTS * ERR_KINDS;
    localparam int CNT_IDX_W     = $clog2(NUM_CNT);
    localparam int CNT_W         = 16;
    localparam int TICKS_PER_REV = 65536;

    // Field widths
    localparam int JOINT_W  = 3;
    localparam int RAW_W    = 20;
    localparam int VAL_W    = 16;
    localparam int POS_W    = 18;
    localparam int STATUS_W = 3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_READ    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PARITY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOCONN  = 3'd4;

    // Encoder type codes
    localparam logic [1:0] ENC_NONE  = 2'd0;
    localparam logic [1:0] ENC_ABS   = 2'd1;
    localparam logic [1:0] ENC_MULTI = 2'd2;
    localparam logic [1:0] ENC_INC   = 2'd3;

    // Full-scale values per encoder type
    localparam longint unsigned FS_ABS   = 65520;
    localparam longint unsigned FS_MULTI = 65535;
    localparam longint unsigned FS_INC   = 28671;

    // Reciprocal multipliers: pos = (value * MAG) >> MAG_SHIFT is exact for
    // 16-bit values since value * (MAG * fs - TICKS * 2^MAG_SHIFT) < 2^MAG_SHIFT.
    localparam int MAG_SHIFT = 32;
    localparam int MAG_W     = 34;
    localparam int PROD_W    = VAL_W + MAG_W;
    localparam logic [MAG_W-1:0] MAG_ABS = MAG_W'(
        ((64'(TICKS_PER_REV) << MAG_SHIFT) + FS_ABS - 64'd1) / FS_ABS);
    localparam logic [MAG_W-1:0] MAG_MULTI = MAG_W'(
        ((64'(TICKS_PER_REV) << MAG_SHIFT) + FS_MULTI - 64'd1) / FS_MULTI);
    localparam logic [MAG_W-1:0] MAG_INC = MAG_W'(
        ((64'(TICKS_PER_REV) << MAG_SHIFT) + FS_INC - 64'd1) / FS_INC);

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic               is_extra;
        logic [RAW_W-1:0]   raw_word;
        logic               read_ok;
    } reading_t;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [STATUS_W-1:0] status;
        logic                word_fault;
        logic [CNT_W-1:0]    error_count;
    } result_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    value;
        logic [1:0]          enc;
        logic                bump;
    } dec_t;

    typedef struct packed {
        logic                bump;
        logic [JOINT_W-1:0]  joint;
        logic [STATUS_W-1:0] status;
    } cnt_req_t;

endpackage

`default_nettype wire

>>> rtl/jewd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module jewd_decode (
    input  wire jewd_pkg::reading_t        item,
    input  wire logic [jewd_pkg::MAP_W-1:0] type_map,
    output jewd_pkg::dec_t                 dec
);

    logic [jewd_pkg::JOINT_W:0] slot;
    logic                       connected;
    logic [1:0]                 enc;
    logic                       parity;

    always_comb
    begin
        slot      = {item.joint, item.is_extra};
        connected = (int'(item.joint) < jewd_pkg::NUM_JOINTS) &&
                    (int'(slot) < jewd_pkg::MAP_SLOTS);
        enc       = connected ? 2'(type_map >> {slot, 1'b0}) : jewd_pkg::ENC_NONE;
        parity    = ^item.raw_word[17:0];

        dec.status = jewd_pkg::ST_OK;
        dec.value  = '0;
        dec.enc    = enc;

        case (enc)
            jewd_pkg::ENC_NONE:
            begin
                dec.status = jewd_pkg::ST_NOCONN;
            end
            jewd_pkg::ENC_INC:
            begin
                // counter is always readable: ignore the link flag
                dec.value = item.raw_word[15:0];
            end
            jewd_pkg::ENC_ABS:
            begin
                if (!item.read_ok)
                    dec.status = jewd_pkg::ST_READ;
                else if (parity)
                    dec.status = jewd_pkg::ST_PARITY;
                else if (item.raw_word[5:3] != 3'b100)
                    dec.status = jewd_pkg::ST_INVALID;
                else
                    dec.value = {item.raw_word[17:6], 4'b0000};
            end
            default:
            begin
                if (!item.read_ok)
                    dec.status = jewd_pkg::ST_READ;
                else
                    dec.value = item.raw_word[19:4];
            end
        endcase

        dec.bump = (dec.status == jewd_pkg::ST_READ) ||
                   (dec.status == jewd_pkg::ST_PARITY) ||
                   (dec.status == jewd_pkg::ST_INVALID);
    end

endmodule

`default_nettype wire

>>> rtl/jewd_rescale.sv
`timescale 1ns / 1ps
`default_nettype none

module jewd_rescale (
    input  wire logic [jewd_pkg::VAL_W-1:0] value,
    input  wire logic [1:0]                 enc,
    output logic [jewd_pkg::POS_W-1:0]      position
);

    logic [jewd_pkg::MAG_W-1:0]  mag;
    logic [jewd_pkg::PROD_W-1:0] prod;

    always_comb
    begin
        case (enc)
            jewd_pkg::ENC_ABS:   mag = jewd_pkg::MAG_ABS;
            jewd_pkg::ENC_MULTI: mag = jewd_pkg::MAG_MULTI;
            jewd_pkg::ENC_INC:   mag = jewd_pkg::MAG_INC;
            default:             mag = '0;
        endcase
        prod     = jewd_pkg::PROD_W'(value) * jewd_pkg::PROD_W'(mag);
        position = prod[jewd_pkg::MAG_SHIFT +: jewd_pkg::POS_W];
    end

endmodule

`default_nettype wire

>>> rtl/jewd_err_cnt.sv
`timescale 1ns / 1ps
`default_nettype none

module jewd_err_cnt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire jewd_pkg::cnt_req_t         req,
    output logic [jewd_pkg::CNT_W-1:0]      count
);

    localparam int IDX_WW = jewd_pkg::CNT_IDX_W + 1;

    logic [jewd_pkg::CNT_W-1:0]     cnt_reg [jewd_pkg::NUM_CNT];
    logic [IDX_WW-1:0]              idx_wide;
    logic [jewd_pkg::CNT_IDX_W-1:0] idx;
    logic                           hit;
    logic [jewd_pkg::CNT_W-1:0]     cur;
    logic [jewd_pkg::CNT_W-1:0]     cnt_next;

    always_comb
    begin
        idx_wide = IDX_WW'(req.joint) * IDX_WW'(jewd_pkg::ERR_KINDS) +
                   IDX_WW'(req.status) - IDX_WW'(1);
        idx      = idx_wide[jewd_pkg::CNT_IDX_W-1:0];
        hit      = ((req.status == jewd_pkg::ST_READ) ||
                    (req.status == jewd_pkg::ST_PARITY) ||
                    (req.status == jewd_pkg::ST_INVALID)) &&
                   (idx_wide < IDX_WW'(jewd_pkg::NUM_CNT));
        cur      = hit ? cnt_reg[idx] : '0;
        // saturate at full scale
        cnt_next = (&cur) ? cur : cur + jewd_pkg::CNT_W'(1);
        count    = hit ? cnt_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < jewd_pkg::NUM_CNT; i++)
                cnt_reg[i] <= '0;
        end
        else if (req.bump && hit)
        begin
            cnt_reg[idx] <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/joint_encoder_word_decoder_unit.sv
// Pipeline: an accepted request is loaded into the input register, then moves into the
// result register once that register is free, so it can wait in the input register.
// Throughput: one request per cycle; the result register frees the input side
// as soon as the downstream takes the pending result.
// Reset (rst_n, async, active low): pipeline empty, type map zero (all slots
// unconnected), all per-joint error counters zero.
`timescale 1ns / 1ps
`default_nettype none

module joint_encoder_word_decoder_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // encoder readings
    input  wire logic                       reading_valid,
    output logic                            reading_ready,
    input  wire jewd_pkg::reading_t         reading,
    // decoded results
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output jewd_pkg::result_t               result,
    // encoder type map write
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [jewd_pkg::MAP_W-1:0] cfg_data
);

    // Configuration register: always writable
    logic [jewd_pkg::MAP_W-1:0] type_map_reg;

    // Input stage
    logic               s1_valid_reg;
    logic               s1_valid_next;
    jewd_pkg::reading_t s1_item_reg;

    // Result stage
    logic               out_valid_reg;
    logic               out_valid_next;
    jewd_pkg::result_t  out_data_reg;
    jewd_pkg::result_t  out_data_next;

    logic               out_free;
    logic               advance;
    logic               take_in;

    jewd_pkg::dec_t             dec;
    jewd_pkg::cnt_req_t         cnt_req;
    logic [jewd_pkg::CNT_W-1:0] cnt_value;
    logic [jewd_pkg::POS_W-1:0] scaled_pos;

    assign cfg_ready = 1'b1;

    // The result register is free when empty or being drained this cycle.
    assign out_free      = !out_valid_reg || result_ready;
    assign advance       = s1_valid_reg && out_free;
    assign reading_ready = !s1_valid_reg || out_free;
    assign take_in       = reading_valid && reading_ready;

    // Decode the held request against the current type map.
    jewd_decode u_decode (
        .item     (s1_item_reg),
        .type_map (type_map_reg),
        .dec      (dec)
    );

    // Rescale to ticks per revolution with a single reciprocal multiply.
    jewd_rescale u_rescale (
        .value    (dec.value),
        .enc      (dec.enc),
        .position (scaled_pos)
    );

    // Bump the error counter only when the request moves into the result
    // register, so a stalled request is counted exactly once.
    always_comb
    begin
        cnt_req.bump   = advance && dec.bump;
        cnt_req.joint  = s1_item_reg.joint;
        cnt_req.status = dec.status;
    end

    jewd_err_cnt u_err_cnt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cnt_req),
        .count (cnt_value)
    );

    always_comb
    begin
        out_data_next.position    = (dec.status == jewd_pkg::ST_OK) ? scaled_pos : '0;
        out_data_next.status      = dec.status;
        out_data_next.word_fault  = (dec.status == jewd_pkg::ST_PARITY) ||
                                    (dec.status == jewd_pkg::ST_INVALID);
        out_data_next.error_count = cnt_value;
    end

    // Hold the input stage until the result register can take it.
    always_comb
    begin
        if (take_in)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_map_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                type_map_reg <= cfg_data;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load only, no reset needed.
    always_ff @(posedge clk)
    begin
        if (take_in)
            s1_item_reg <= reading;
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef SYNTH
    // A failed decode never carries a position.
    a_pos_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != jewd_pkg::ST_OK) |-> result.position == '0)
        else $error("position nonzero with error status");

    // The word fault flag marks exactly the validation failures.
    a_word_fault: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.word_fault ==
            ((result.status == jewd_pkg::ST_PARITY) ||
             (result.status == jewd_pkg::ST_INVALID)))
        else $error("word_fault inconsistent with status");

    // No counter value is reported for success or an unconnected slot.
    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result.status == jewd_pkg::ST_OK) ||
                         (result.status == jewd_pkg::ST_NOCONN))
        |-> result.error_count == '0)
        else $error("error_count reported without counted error");

    // An advancing request always lands in the result register.
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request lost");

    // Backpressure only comes from a held request with a blocked result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !reading_ready |-> s1_valid_reg && out_valid_reg && !result_ready)
        else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import jewd_pkg::*;

    // Status field of a well-formed absolute word, raw bits 5..3
    localparam logic [2:0] ABS_STAT_OK = 3'b100;
    // Generous cycle budget for the whole run
    localparam int CYCLE_LIMIT = 4_000_000;

    // Receiver stall patterns
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_e;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 reading_valid = 1'b0;
    logic                 reading_ready;
    reading_t             reading = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b1;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [MAP_W-1:0]     cfg_data = '0;

    // Requests waiting for the driver, and decoded results still owed by the block
    reading_t             readings_q[$];
    result_t              decoded_q[$];

    // Shadow copy of the block's type map and error counters
    logic [MAP_W-1:0]     type_map = '0;
    logic [CNT_W-1:0]     joint_err_cnt [NUM_CNT];

    // Handshake flags registered at the rising edge, read at the falling edge
    logic                 rd_fire = 1'b0;
    logic                 cfg_fire = 1'b0;

    int                   mismatches = 0;
    int                   cycles = 0;
    int                   burst_left = 8;
    int                   gap_left = 0;
    int                   rx_ticks = 0;
    logic [1:0]           rx_phase = '0;
    rx_mode_e             rx_mode = RX_OPEN;

    joint_encoder_word_decoder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .reading_valid (reading_valid),
        .reading_ready (reading_ready),
        .reading       (reading),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run: a missing result or a stuck ready lands here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, decoded_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Build an absolute encoder word: bits 19..18 and 2..1 are don't-care noise,
    // bit 0 fixes the parity over bits 17..0 (even unless a parity error is wanted).
    function automatic logic [RAW_W-1:0] abs_word(logic [11:0] pos_bits, logic [2:0] stat,
                                                  logic bad_parity);
        logic [RAW_W-1:0] w;
        w = {2'($urandom), pos_bits, stat, 2'($urandom), 1'b0};
        w[0] = (^w[17:1]) ^ bad_parity;
        return w;
    endfunction

    function automatic void queue_reading(logic [JOINT_W-1:0] joint, logic is_extra,
                                          logic [RAW_W-1:0] raw_word, logic read_ok);
        reading_t r;
        r.joint    = joint;
        r.is_extra = is_extra;
        r.raw_word = raw_word;
        r.read_ok  = read_ok;
        readings_q.push_back(r);
    endfunction

    // Decode one encoder reading against the shadow type map and bump the
    // shadow error counter the way the block must.
    function automatic result_t decode_reading(reading_t r);
        logic [3:0]          slot;
        logic [1:0]          enc;
        logic [STATUS_W-1:0] st;
        logic [VAL_W-1:0]    value;
        longint unsigned     fullscale;
        int                  idx;
        result_t             res;
        slot      = {r.joint, r.is_extra};
        enc       = ENC_NONE;
        st        = ST_OK;
        value     = '0;
        fullscale = FS_INC;
        res       = '0;
        // Joints past the last one and slots past the map read as unconnected
        if (r.joint < NUM_JOINTS && slot < MAP_SLOTS)
            enc = type_map[2*slot +: 2];
        case (enc)
            ENC_NONE:
                st = ST_NOCONN;
            ENC_INC:
            begin
                // Counter is always available, read_ok does not matter
                value     = r.raw_word[15:0];
                fullscale = FS_INC;
            end
            default:
            begin
                if (!r.read_ok)
                    st = ST_READ;
                else if (enc == ENC_ABS)
                begin
                    if (^r.raw_word[17:0])
                        st = ST_PARITY;
                    else if (r.raw_word[5:3] != ABS_STAT_OK)
                        st = ST_INVALID;
                    else
                    begin
                        value     = {r.raw_word[17:6], 4'h0};
                        fullscale = FS_ABS;
                    end
                end
                else
                begin
                    value     = r.raw_word[19:4];
                    fullscale = FS_MULTI;
                end
            end
        endcase
        res.status     = st;
        res.word_fault = (st == ST_PARITY || st == ST_INVALID);
        if (st == ST_OK)
            res.position = POS_W'((64'(TICKS_PER_REV) * 64'(value)) / fullscale);
        else if (st != ST_NOCONN)
        begin
            // Saturating counter per joint and error kind
            idx = ERR_KINDS * int'(r.joint) + int'(st) - 1;
            if (joint_err_cnt[idx] != '1)
                joint_err_cnt[idx] = joint_err_cnt[idx] + 1'b1;
            res.error_count = joint_err_cnt[idx];
        end
        return res;
    endfunction

    task automatic flag_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Driver: hand out requests in bursts of random length with random gaps.
    // Hold valid and payload until the request is taken.
    always @(negedge clk)
    begin
        if (!reading_valid || rd_fire)
        begin
            if (gap_left > 0 || readings_q.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                reading_valid <= 1'b0;
            end
            else
            begin
                reading       <= readings_q.pop_front();
                reading_valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    // Close the burst; about two in five bursts follow back to back
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Receiver: switch between stall patterns at random intervals.
    always @(negedge clk)
    begin
        if (rx_ticks == 0)
        begin
            rx_mode  = rx_mode_e'($urandom_range(0, 3));
            rx_ticks = $urandom_range(16, 96);
        end
        else
            rx_ticks--;
        rx_phase = rx_phase + 1'b1;
        case (rx_mode)
            RX_OPEN:   result_ready <= 1'b1;
            RX_COIN:   result_ready <= 1'($urandom);
            RX_EVERY4: result_ready <= (rx_phase == 2'd0);
            default:   result_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Monitor: track handshakes, predict on every accepted request and check
    // every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            rd_fire  <= reading_valid && reading_ready;
            cfg_fire <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
                type_map = cfg_data;
            // Check before predicting so a stray result never pairs with this cycle's request
            if (result_valid && result_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual %p",
                             $time, result);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    flag_field("position", want.position, result.position);
                    flag_field("status", want.status, result.status);
                    flag_field("word_fault", want.word_fault, result.word_fault);
                    flag_field("error_count", want.error_count, result.error_count);
                end
            end
            if (reading_valid && reading_ready)
                decoded_q.push_back(decode_reading(reading));
        end
    end

    // Write the type map; only called while nothing is in flight.
    task automatic write_type_map(logic [MAP_W-1:0] map_val);
        @(negedge clk);
        cfg_data  <= map_val;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (!cfg_fire)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every request is out and every result is back. Look a moment
    // after the falling edge so the driver's updates at that edge have landed.
    task automatic wait_idle();
        @(negedge clk);
        #1;
        while (readings_q.size() != 0 || reading_valid || decoded_q.size() != 0)
        begin
            @(negedge clk);
            #1;
        end
    endtask

    initial
    begin
        logic [MAP_W-1:0]   map_val;
        logic [JOINT_W-1:0] joint_v;
        logic               extra_v;
        logic               ok_v;
        logic [RAW_W-1:0]   raw_v;
        logic [1:0]         enc;
        logic [2:0]         stat;
        logic [11:0]        pos_bits;
        int                 pick;
        int                 n_items;

        foreach (joint_err_cnt[i])
            joint_err_cnt[i] = '0;

        // Hold reset from time zero, drop it away from the rising edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Map still at its reset value: every slot reads as unconnected
        queue_reading(3'd0, 1'b0, '1, 1'b1);
        queue_reading(3'd5, 1'b1, '0, 1'b0);
        wait_idle();

        // Directed map: every encoder type on the extra slots, all but multi-turn on the main slots
        map_val = {ENC_MULTI, ENC_ABS, ENC_NONE, ENC_INC, ENC_MULTI, ENC_ABS,
                   ENC_ABS, ENC_NONE, ENC_INC, ENC_INC, ENC_MULTI, ENC_ABS};
        write_type_map(map_val);
        @(posedge clk);
        // Absolute: full scale, zero, parity error twice, bad status bits, read failure
        queue_reading(3'd0, 1'b0, abs_word('1, ABS_STAT_OK, 1'b0), 1'b1);
        queue_reading(3'd0, 1'b0, abs_word('0, ABS_STAT_OK, 1'b0), 1'b1);
        queue_reading(3'd0, 1'b0, abs_word(12'h5A5, ABS_STAT_OK, 1'b1), 1'b1);
        queue_reading(3'd0, 1'b0, abs_word(12'hA5A, 3'b000, 1'b1), 1'b1);
        queue_reading(3'd0, 1'b0, abs_word(12'h123, 3'b000, 1'b0), 1'b1);
        queue_reading(3'd0, 1'b0, abs_word(12'h321, 3'b111, 1'b0), 1'b1);
        queue_reading(3'd0, 1'b0, abs_word(12'h777, 3'b101, 1'b0), 1'b1);
        queue_reading(3'd0, 1'b0, abs_word(12'h456, ABS_STAT_OK, 1'b0), 1'b0);
        // Multi-turn: full scale, zero, read failure
        queue_reading(3'd0, 1'b1, '1, 1'b1);
        queue_reading(3'd0, 1'b1, '0, 1'b1);
        queue_reading(3'd0, 1'b1, 20'h12345, 1'b0);
        // Incremental: full count, zero; a failed read does not matter on either slot
        queue_reading(3'd1, 1'b0, '1, 1'b1);
        queue_reading(3'd1, 1'b0, '0, 1'b0);
        queue_reading(3'd1, 1'b1, 20'hA5A5A, 1'b0);
        queue_reading(3'd4, 1'b0, 20'h0FFFF, 1'b1);
        // Unconnected slot and joints past the last one
        queue_reading(3'd2, 1'b0, '1, 1'b1);
        queue_reading(3'd6, 1'b0, abs_word('1, ABS_STAT_OK, 1'b0), 1'b1);
        queue_reading(3'd7, 1'b1, '1, 1'b1);
        // Other joints on both slot kinds
        queue_reading(3'd5, 1'b1, 20'hFFFF0, 1'b1);
        queue_reading(3'd5, 1'b0, abs_word(12'h800, ABS_STAT_OK, 1'b0), 1'b1);
        queue_reading(3'd2, 1'b1, abs_word(12'h0F0, ABS_STAT_OK, 1'b1), 1'b1);
        queue_reading(3'd3, 1'b0, abs_word(12'hFFE, ABS_STAT_OK, 1'b0), 1'b1);
        wait_idle();

        // Random phases under uniform and random maps, ending with all slots unconnected
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       map_val = {MAP_SLOTS{ENC_INC}};
                1:       map_val = {MAP_SLOTS{ENC_ABS}};
                2:       map_val = {MAP_SLOTS{ENC_MULTI}};
                7:       map_val = {MAP_SLOTS{ENC_NONE}};
                default: map_val = MAP_W'($urandom);
            endcase
            write_type_map(map_val);
            @(posedge clk);
            n_items = (ph == 7) ? 60 : 260;
            repeat (n_items)
            begin
                // Mostly real joints, now and then one past the end
                if ($urandom_range(0, 9) == 0)
                    joint_v = JOINT_W'($urandom_range(NUM_JOINTS, 7));
                else
                    joint_v = JOINT_W'($urandom_range(0, NUM_JOINTS - 1));
                extra_v = 1'($urandom);
                ok_v    = ($urandom_range(0, 9) != 0);
                enc     = ENC_NONE;
                if (joint_v < NUM_JOINTS)
                    enc = map_val[4*joint_v + 2*extra_v +: 2];
                pick  = $urandom_range(0, 19);
                raw_v = RAW_W'($urandom);
                if (enc == ENC_ABS)
                begin
                    // Mostly well-formed words so decoding gets past the checks
                    stat = 3'($urandom);
                    if (stat == ABS_STAT_OK)
                        stat = ~stat;
                    pos_bits = (pick == 0) ? '1 : (pick == 1) ? '0 : 12'($urandom);
                    if (pick < 14)
                        raw_v = abs_word(pos_bits, ABS_STAT_OK, 1'b0);
                    else if (pick < 16)
                        raw_v = abs_word(pos_bits, 3'($urandom), 1'b1);
                    else if (pick < 18)
                        raw_v = abs_word(pos_bits, stat, 1'b0);
                end
                else if (pick == 0)
                    raw_v = '1;
                else if (pick == 1)
                    raw_v = '0;
                queue_reading(joint_v, extra_v, raw_v, ok_v);
            end
            wait_idle();
        end

        // Let a stray late result show up before the verdict
        repeat (4) @(posedge clk);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
rtl/jewd_pkg.sv
rtl/jewd_decode.sv
rtl/jewd_rescale.sv
rtl/jewd_err_cnt.sv
rtl/joint_encoder_word_decoder_unit.sv
bench/testbench.sv
